>>> design/multi_graph_shortest_path_switches_macros.svh
// Assertion macros used by the top-level module.
`ifndef MULTI_GRAPH_SHORTEST_PATH_SWITCHES_MACROS_SVH
`define MULTI_GRAPH_SHORTEST_PATH_SWITCHES_MACROS_SVH
// Property a implies property b, sampled on clk, off during rst.
`define MGSP_ASSERT_IMP(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Property a implies b in the next cycle.
`define MGSP_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

>>> design/mgsp_pkg.sv
// ----------------------------------------------------------------------------
// mgsp_pkg
// Shared constants, types and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package mgsp_pkg;
  localparam int MaxNodes    = 32;
  localparam int MaxVehicles = 32;
  localparam int NodeW       = $clog2(MaxNodes);
  localparam int VehW        = $clog2(MaxVehicles);
  localparam int DistW       = 30;
  localparam int CntW        = 6;
  localparam logic [DistW-1:0] NoPath = 30'd1000000000;

  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpCompute = 2'd1;
  localparam logic [1:0] OpQuery   = 2'd2;

  localparam logic CfgNodes    = 1'b0;
  localparam logic CfgVehicles = 1'b1;

  // Datapath commands issued by the controller each cycle.
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,
    CMD_FW     = 4'd2,
    CMD_L0     = 4'd3,
    CMD_MP     = 4'd4,
    CMD_QUERY  = 4'd5,
    CMD_ACC    = 4'd6,
    CMD_FW_ROW = 4'd7
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t            code;
    logic              first;   // restart accumulator
    logic              last;    // write accumulator result
    logic [VehW-1:0]   t;
    logic [NodeW-1:0]  k;
    logic [NodeW-1:0]  i;
    logic [NodeW-1:0]  j;
    logic [NodeW-1:0]  p;
  } cmd_t;

  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, NoPath}) ? NoPath : s[DistW-1:0];
  endfunction
endpackage

>>> design/mgsp_datapath.sv
// ----------------------------------------------------------------------------
// mgsp_datapath
// Graph and layer memories with a min/plus unit.
// Commands read the memories into registers, then combine; a load writes directly.
// ----------------------------------------------------------------------------
module mgsp_datapath import mgsp_pkg::*; (
  input  logic              clk,
  input  cmd_t              cmd,
  input  logic [19:0]       weight,
  output logic [DistW-1:0]  result
);
  localparam int AW = VehW + 2*NodeW;
  localparam int LW = 3*NodeW;

  logic [DistW-1:0] vmem [2**AW];
  logic [DistW-1:0] lmem [2**LW];
  logic [DistW-1:0] va, vb, vc, la, lb;
  cmd_t             c1;
  logic [DistW-1:0] acc;
  logic [DistW-1:0] cand;

  // Read stage. Vehicle memory: two reads a cycle (kj, ij). A row fetch
  // latches ik, which holds still for the whole row under one pivot.
  always_ff @(posedge clk) begin
    vb <= vmem[(cmd.code == CMD_FW_ROW) ? {cmd.t, cmd.i, cmd.k} :
                                          {cmd.t, cmd.k, cmd.j}];
    vc <= vmem[{cmd.t, cmd.i, cmd.j}];
    if (c1.code == CMD_FW_ROW) va <= vb;
    la <= lmem[{(cmd.code == CMD_QUERY) ? cmd.p : cmd.k - NodeW'(1), cmd.i,
                (cmd.code == CMD_QUERY) ? cmd.j : cmd.p}];
    lb <= lmem[{NodeW'(0), cmd.p, cmd.j}];
    c1 <= cmd;
  end

  always_comb begin
    unique case (c1.code)
      CMD_MP:  cand = sat_add(la, lb);
      CMD_L0:  cand = vc;
      CMD_QUERY: cand = la;
      default: cand = NoPath;
    endcase
  end

  // Combine stage: a load writes its weight, FW writes back a shorter path, L0/MP/query fold into acc.
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LOAD) begin
      vmem[{cmd.t, cmd.i, cmd.j}] <= {10'd0, weight};
    end else if (c1.code == CMD_FW) begin
      if (sat_add(va, vb) < vc) vmem[{c1.t, c1.i, c1.j}] <= sat_add(va, vb);
    end
    if (c1.code == CMD_L0 || c1.code == CMD_MP || c1.code == CMD_QUERY) begin
      if (c1.first) acc <= (cand < NoPath) ? cand : NoPath;
      else if (cand < acc) acc <= cand;
      if (c1.last && c1.code != CMD_QUERY) begin
        lmem[{c1.k, c1.i, c1.j}] <= (c1.first || cand < acc) ?
          ((cand < NoPath) ? cand : NoPath) : acc;
      end
    end
  end

  assign result = acc;
endmodule

>>> design/mgsp_ctrl.sv
// ----------------------------------------------------------------------------
// mgsp_ctrl
// Sequencer: walks the loop nests of load, compute and query items.
// ----------------------------------------------------------------------------
module mgsp_ctrl import mgsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [VehW-1:0]   vehicle,
  input  logic [NodeW-1:0]  from_node,
  input  logic [NodeW-1:0]  to_node,
  input  logic [9:0]        change_limit,
  input  logic [CntW-1:0]   n_eff,
  input  logic [CntW-1:0]   m_eff,
  output cmd_t              cmd,
  output logic              res_load,
  output logic              res_nopath
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_FWROW = 7'b0000010, S_FW = 7'b0000100,
    S_L0 = 7'b0001000, S_MP = 7'b0010000, S_QRY = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_t;

  state_t state, resume;
  logic [VehW-1:0]  t;
  logic [NodeW-1:0] k, i, j, p, qtop;
  logic [1:0]       drain;
  logic             drain_res, nopath;
  logic [NodeW-1:0] nl;
  logic [VehW-1:0]  ml;

  assign nl = NodeW'(n_eff - CntW'(1));
  assign ml = VehW'(m_eff - CntW'(1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.code = CMD_NONE;
    cmd.t = t; cmd.k = k; cmd.i = i; cmd.j = j; cmd.p = p;
    unique case (state)
      S_IDLE: begin
        if (in_valid && op == OpLoad) begin
          cmd.code = CMD_LOAD; cmd.t = vehicle; cmd.i = from_node; cmd.j = to_node;
        end
      end
      S_FWROW: cmd.code = CMD_FW_ROW;
      S_FW: cmd.code = CMD_FW;
      S_L0: begin
        cmd.code = CMD_L0; cmd.k = '0; cmd.first = (t == '0); cmd.last = (t == ml);
      end
      S_MP: begin
        cmd.code = CMD_MP; cmd.first = (p == '0); cmd.last = (p == nl);
      end
      S_QRY: begin
        cmd.code = CMD_QUERY; cmd.first = (p == '0); cmd.last = (p == qtop);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_load <= !rst && (state == S_DRAIN) && (drain == '0) && drain_res;
    if (rst) begin
      state <= S_IDLE; resume <= S_IDLE;
      t <= '0; k <= '0; i <= '0; j <= '0; p <= '0; drain <= '0;
      drain_res <= 1'b0; nopath <= 1'b0; qtop <= '0; res_nopath <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          t <= '0; k <= '0; p <= '0;
          i <= (op == OpQuery) ? from_node : '0;
          j <= (op == OpQuery) ? to_node : '0;
          if (op == OpCompute) state <= S_FWROW;
          else if (op == OpQuery) begin
            nopath <= ({1'b0, from_node} >= n_eff) || ({1'b0, to_node} >= n_eff);
            qtop <= (change_limit < 10'(nl)) ? NodeW'(change_limit) : nl;
            state <= S_QRY;
          end
        end
        // Latch the pivot-column entry of the row.
        S_FWROW: state <= S_FW;
        S_FW: begin
          if (j != nl) j <= j + 1'b1;
          else begin
            j <= '0;
            if (i != nl) begin
              i <= i + 1'b1; state <= S_FWROW;
            end else begin
              // Let the last write of the pivot land before the next one.
              i <= '0;
              drain <= 2'd2; drain_res <= 1'b0; state <= S_DRAIN;
              if (k != nl) begin
                k <= k + 1'b1; resume <= S_FWROW;
              end else begin
                k <= '0;
                if (t != ml) begin
                  t <= t + 1'b1; resume <= S_FWROW;
                end else begin
                  t <= '0; resume <= S_L0;
                end
              end
            end
          end
        end
        S_L0: begin
          if (t != ml) t <= t + 1'b1;
          else begin
            t <= '0;
            if (j != nl) j <= j + 1'b1;
            else begin
              j <= '0;
              if (i != nl) i <= i + 1'b1;
              else begin
                i <= '0; k <= NodeW'(1);
                drain <= 2'd2; drain_res <= 1'b0;
                resume <= (nl == '0) ? S_IDLE : S_MP;
                state <= S_DRAIN;
              end
            end
          end
        end
        S_MP: begin
          if (p != nl) p <= p + 1'b1;
          else begin
            p <= '0;
            if (j != nl) j <= j + 1'b1;
            else begin
              j <= '0;
              if (i != nl) i <= i + 1'b1;
              else begin
                i <= '0; drain <= 2'd2; drain_res <= 1'b0; state <= S_DRAIN;
                if (k != nl) begin k <= k + 1'b1; resume <= S_MP; end
                else resume <= S_IDLE;
              end
            end
          end
        end
        S_QRY: begin
          if (p != qtop) p <= p + 1'b1;
          else begin
            p <= '0; drain <= 2'd2; drain_res <= 1'b1; state <= S_DRAIN;
            resume <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (drain != '0) drain <= drain - 1'b1;
          else begin
            if (drain_res) res_nopath <= nopath;
            state <= resume;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/multi_graph_shortest_path_switches.sv
// A query takes the minimum over layers 0 to min(change_limit, node_count-1);
// compute builds the layers one (i,j,p) term per cycle through one memory
// port pair.
// One item at a time; a result waits in an output register, and while it
// waits only a new query is held off. Reset (rst, synchronous) clears control
// and sets node_count and vehicle_count to 32; memories are not cleared.
// ----------------------------------------------------------------------------
// multi_graph_shortest_path_switches
// Multi-vehicle all-pairs shortest paths with bounded vehicle changes.
// ----------------------------------------------------------------------------
`include "multi_graph_shortest_path_switches_macros.svh"
module multi_graph_shortest_path_switches import mgsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   op,
  input  logic [4:0]   vehicle,
  input  logic [4:0]   from_node,
  input  logic [4:0]   to_node,
  input  logic [19:0]  weight,
  input  logic [9:0]   change_limit,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [29:0]  distance
);
  logic [CntW-1:0]  node_count, vehicle_count, n_eff, m_eff;
  cmd_t             cmd;
  logic             res_load, res_nopath, ctrl_ready;
  logic [DistW-1:0] acc;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CntW'(MaxNodes); vehicle_count <= CntW'(MaxVehicles);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgNodes:    node_count <= cfg_data;
        CfgVehicles: vehicle_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp to 1..max.
  assign n_eff = (node_count == '0) ? CntW'(1) :
                 (node_count > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count;
  assign m_eff = (vehicle_count == '0) ? CntW'(1) :
                 (vehicle_count > CntW'(MaxVehicles)) ? CntW'(MaxVehicles) : vehicle_count;

  // Hold off a query while a result is unclaimed or about to be captured.
  assign in_ready = ctrl_ready && !((out_valid || res_load) && op == OpQuery);

  mgsp_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_valid && in_ready), .in_ready(ctrl_ready),
    .op, .vehicle, .from_node, .to_node, .change_limit,
    .n_eff, .m_eff, .cmd, .res_load, .res_nopath
  );

  mgsp_datapath u_dp (.clk, .cmd, .weight, .result(acc));

  // Output register: capture, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (res_load) distance <= res_nopath ? NoPath : acc;
  end

  `MGSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready && !res_load, out_valid, "result dropped")
  `MGSP_ASSERT_IMP(a_no_path_range, out_valid, distance <= NoPath, "distance out of range")
endmodule

>>> test/multi_graph_shortest_path_switches_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_graph_shortest_path_switches_tb
// Drives load, compute and distance-query items through the valid/ready
// input channel, predicts each query's distance from a local copy of the
// per-vehicle graphs and change layers, and checks the distance results
// in order. Configuration moves through several node and vehicle counts.
// ----------------------------------------------------------------------------
module multi_graph_shortest_path_switches_tb;
  import mgsp_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int CycleLimit = 2000000;
  localparam int LongHold = 400;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  veh;
    logic [4:0]  u;
    logic [4:0]  v;
    logic [19:0] w;
    logic [9:0]  lim;
  } item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [4:0]  vehicle;
  logic [4:0]  from_node;
  logic [4:0]  to_node;
  logic [19:0] weight;
  logic [9:0]  change_limit;
  logic        out_valid;
  logic        out_ready;
  logic [29:0] distance;

  multi_graph_shortest_path_switches uut (.*);

  // Model copy of the graphs, the change layers and the raw registers.
  logic [29:0] graph_dist [32][32][32];
  logic [29:0] layer_dist [32][32][32];
  logic [5:0]  model_nodes;
  logic [5:0]  model_vehicles;

  // Stimulus side bookkeeping: which entries have been written so far, so
  // that no compute or query touches an entry that is still undefined.
  bit graph_written [32][32][32];
  bit layer_written [32][32][32];
  int gen_n;
  int gen_m;

  item_t       pending_items[$];
  logic [29:0] dist_expect[$];
  int          mismatches;
  int          cycles;
  logic        in_fire;
  int          in_gap;
  int          out_gap;
  int          hold_left;
  bit          hold_request;
  bit          quiet;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int clamp_count(input logic [5:0] raw);
    if (raw == 6'd0) return 1;
    if (raw > 6'd32) return 32;
    return int'(raw);
  endfunction

  function automatic logic [29:0] cost_sum(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, NoPath}) return NoPath;
    return s[29:0];
  endfunction

  // Per-vehicle all-pairs shortest paths, then the layer stack.
  task automatic run_compute();
    int n;
    int m;
    logic [29:0] c;
    logic [29:0] best;
    n = clamp_count(model_nodes);
    m = clamp_count(model_vehicles);
    for (int t = 0; t < m; t++)
      for (int k = 0; k < n; k++)
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            c = cost_sum(graph_dist[t][i][k], graph_dist[t][k][j]);
            if (c < graph_dist[t][i][j]) graph_dist[t][i][j] = c;
          end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        best = NoPath;
        for (int t = 0; t < m; t++)
          if (graph_dist[t][i][j] < best) best = graph_dist[t][i][j];
        layer_dist[0][i][j] = best;
      end
    for (int k = 1; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          best = NoPath;
          for (int p = 0; p < n; p++) begin
            c = cost_sum(layer_dist[k-1][i][p], layer_dist[0][p][j]);
            if (c < best) best = c;
          end
          layer_dist[k][i][j] = best;
        end
  endtask

  // Apply one accepted item to the model; a query queues its distance.
  task automatic model_step();
    int n;
    int top;
    logic [29:0] best;
    n = clamp_count(model_nodes);
    case (op)
      OpLoad: begin
        graph_dist[vehicle][from_node][to_node] = {10'd0, weight};
      end
      OpCompute: begin
        run_compute();
      end
      OpQuery: begin
        best = NoPath;
        if (from_node < n && to_node < n) begin
          top = (change_limit < n - 1) ? int'(change_limit) : n - 1;
          for (int p = 0; p <= top; p++)
            if (layer_dist[p][from_node][to_node] < best)
              best = layer_dist[p][from_node][to_node];
        end
        dist_expect.push_back(best);
      end
      default: begin
      end
    endcase
  endtask

  // Accept side: check results first, then record the accepted item.
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (dist_expect.size() == 0) begin
          $error("distance: result with none expected, actual %0d", distance);
          mismatches++;
        end else begin
          if (distance !== dist_expect[0]) begin
            $error("distance: expected %0d actual %0d", dist_expect[0], distance);
            mismatches++;
          end
          void'(dist_expect.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        model_step();
      end
    end
  end

  // Input driver: hold the item until accepted, then advance or idle.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_t it;
        it = pending_items.pop_front();
        op <= it.op;
        vehicle <= it.veh;
        from_node <= it.u;
        to_node <= it.v;
        weight <= it.w;
        change_limit <= it.lim;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] o, input int veh, input int u, input int v,
                           input int w, input int lim);
    item_t it;
    it.op = o;
    it.veh = veh[4:0];
    it.u = u[4:0];
    it.v = v[4:0];
    it.w = w[19:0];
    it.lim = lim[9:0];
    pending_items.push_back(it);
  endtask

  task automatic push_load(input int veh, input int u, input int v, input int w);
    graph_written[veh][u][v] = 1'b1;
    push_item(OpLoad, veh, u, v, w, $urandom_range(0, 1023));
  endtask

  function automatic bit graphs_ready();
    for (int t = 0; t < gen_m; t++)
      for (int i = 0; i < gen_n; i++)
        for (int j = 0; j < gen_n; j++)
          if (!graph_written[t][i][j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_compute();
    for (int p = 0; p < gen_n; p++)
      for (int i = 0; i < gen_n; i++)
        for (int j = 0; j < gen_n; j++)
          layer_written[p][i][j] = 1'b1;
    push_item(OpCompute, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 31), $urandom_range(0, 1048575), $urandom_range(0, 1023));
  endtask

  // Queue a query, trimming the change limit to layers already computed.
  task automatic push_query(input int u, input int v, input int lim);
    int ok;
    if (u < gen_n && v < gen_n) begin
      ok = 0;
      while (ok < gen_n && layer_written[ok][u][v]) ok++;
      if (ok == 0) return;
      if (ok < gen_n && lim >= ok) lim = $urandom_range(0, ok - 1);
    end
    push_item(OpQuery, $urandom_range(0, 31), u, v, $urandom_range(0, 1048575), lim);
  endtask

  task automatic fill_graphs();
    for (int t = 0; t < gen_m; t++)
      for (int i = 0; i < gen_n; i++)
        for (int j = 0; j < gen_n; j++)
          push_load(t, i, j, $urandom_range(0, 1048575));
  endtask

  // Wait until the block has nothing in flight, then let it settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || dist_expect.size() > 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgNodes) begin
      model_nodes = val;
      gen_n = clamp_count(val);
    end else begin
      model_vehicles = val;
      gen_m = clamp_count(val);
    end
  endtask

  // Random phase: mostly in-range loads and queries, some computes, noise.
  task automatic random_phase(input int count, input int comp_pct, input bit allow_fill);
    int r;
    bit any_compute;
    any_compute = 1'b0;
    if (allow_fill) fill_graphs();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_load($urandom_range(0, gen_m - 1), $urandom_range(0, gen_n - 1),
                  $urandom_range(0, gen_n - 1), $urandom_range(0, 1048575));
      end else if (r < 40 + comp_pct && allow_fill && graphs_ready()) begin
        push_compute();
        any_compute = 1'b1;
      end else if (r < 90) begin
        if ($urandom_range(0, 4) != 0)
          push_query($urandom_range(0, gen_n - 1), $urandom_range(0, gen_n - 1),
                     $urandom_range(0, 1023));
        else
          push_query($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1023));
      end else if (r < 95) begin
        push_item(OpUnused, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 1048575), $urandom_range(0, 1023));
      end else begin
        push_load($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 1048575));
      end
    end
    // Close with a query so a trailing compute has finished when results drain.
    if (any_compute) push_query(0, 0, $urandom_range(0, 1023));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CfgNodes;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OpLoad;
    vehicle = '0;
    from_node = '0;
    to_node = '0;
    weight = '0;
    change_limit = '0;
    out_ready = 1'b0;
    in_fire = 1'b0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_request = 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    cycles = 0;
    model_nodes = 6'd32;
    model_vehicles = 6'd32;
    gen_n = 32;
    gen_m = 32;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: three nodes, two vehicles, weight extremes, range edges.
    write_config(CfgNodes, 6'd3);
    write_config(CfgVehicles, 6'd2);
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          push_load(t, i, j, (i == j) ? 0 : ((t + i + j) % 2 ? 1048575 : 1000 * (i + 1)));
    push_load(31, 31, 31, 1048575);
    push_item(OpUnused, 31, 31, 31, 1048575, 1023);
    push_compute();
    push_query(0, 2, 0);
    push_query(2, 0, 1023);
    push_query(1, 1, 1);
    push_query(31, 0, 5);
    push_query(0, 31, 2);
    push_load(1, 0, 2, 0);
    push_compute();
    push_query(0, 2, 1);
    push_query(2, 1, 1023);
    drain();

    // Node count zero clamps to one node; one vehicle.
    write_config(CfgNodes, 6'd0);
    write_config(CfgVehicles, 6'd1);
    random_phase(60, 10, 1'b1);
    drain();

    write_config(CfgNodes, 6'd2);
    write_config(CfgVehicles, 6'd32);
    random_phase(80, 8, 1'b1);
    drain();

    write_config(CfgNodes, 6'd6);
    write_config(CfgVehicles, 6'd3);
    random_phase(100, 6, 1'b1);
    drain();

    // Out-of-range register values clamp to the maximum; no compute here.
    write_config(CfgNodes, 6'd63);
    write_config(CfgVehicles, 6'd63);
    random_phase(60, 0, 1'b0);
    drain();

    // Long receiver hold-off while items keep coming.
    write_config(CfgNodes, 6'd8);
    write_config(CfgVehicles, 6'd1);
    hold_request = 1'b1;
    random_phase(120, 4, 1'b1);
    drain();

    // Final stretch without idling on either side.
    write_config(CfgNodes, 6'd2);
    write_config(CfgVehicles, 6'd5);
    quiet = 1'b1;
    random_phase(100, 8, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/mgsp_pkg.sv
design/mgsp_datapath.sv
design/mgsp_ctrl.sv
design/multi_graph_shortest_path_switches.sv
test/multi_graph_shortest_path_switches_tb.sv
